@@ hw/rtl/btil_pkg.sv @@
// Shared types, widths and the helper function of the bitmap to index list unit.
`timescale 1ns / 1ps

package btil_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;

  // Register indexes; register i sits at byte address 4*i.
  typedef enum logic {
    REG_MATCH = 1'b0,
    REG_BASE  = 1'b1
  } btil_reg_t;

  // Word handed from the front to the back: already inverted if clear bits are searched.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [IDX_W-1:0]  base;
    logic              last;
  } btil_job_t;

  // Live configuration seen by the front.
  typedef struct packed {
    logic             match_value;
    logic [IDX_W-1:0] index_offset;
  } btil_cfg_t;

  // Queue status towards the front.
  typedef struct packed {
    logic full;
    logic empty;
  } btil_q_stat_t;

  // Bit-position masks of a one-hot to binary encoder.
  localparam logic [WORD_W-1:0] POS_MASK [POS_W] = '{
    64'hAAAA_AAAA_AAAA_AAAA,
    64'hCCCC_CCCC_CCCC_CCCC,
    64'hF0F0_F0F0_F0F0_F0F0,
    64'hFF00_FF00_FF00_FF00,
    64'hFFFF_0000_FFFF_0000,
    64'hFFFF_FFFF_0000_0000
  };

  // Position of the lowest set bit; zero for an empty word.
  function automatic logic [POS_W-1:0] lowest_pos(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] iso;
    logic [POS_W-1:0]  pos;
    iso = w & (~w + WORD_W'(1));
    for (int k = 0; k < POS_W; k++) begin
      pos[k] = |(iso & POS_MASK[k]);
    end
    return pos;
  endfunction

endpackage

@@ hw/rtl/btil_in_if.sv @@
// Input channel: one bitmap word per item.
`timescale 1ns / 1ps

interface btil_in_if;
  logic                       valid;
  logic                       ready;
  logic [btil_pkg::WORD_W-1:0] word;
  logic                       last_word;

  modport source (output valid, word, last_word, input ready);
  modport sink   (input valid, word, last_word, output ready);
endinterface

@@ hw/rtl/btil_out_if.sv @@
// Result channel: one index per item.
`timescale 1ns / 1ps

interface btil_out_if;
  logic                       valid;
  logic                       ready;
  logic [btil_pkg::IDX_W-1:0] index;
  logic [btil_pkg::IDX_W-1:0] slot;
  logic                       found;
  logic                       last_of_word;

  modport source (output valid, index, slot, found, last_of_word, input ready);
  modport sink   (input valid, index, slot, found, last_of_word, output ready);
endinterface

@@ hw/rtl/btil_front.sv @@
// Front end: accepts words, applies the match polarity and tags each with its index base.
`timescale 1ns / 1ps

module btil_front #(
  parameter int unsigned MAX_WORDS = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  btil_in_if.sink              in_ch,
  input  btil_pkg::btil_cfg_t  cfg,
  input  btil_pkg::btil_q_stat_t q_stat,
  output logic                 push,
  output btil_pkg::btil_job_t  push_job
);

  localparam int unsigned WN_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  logic [WN_W-1:0] word_number_r;
  logic [WN_W-1:0] word_number_nxt;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    push_job.word = cfg.match_value ? in_ch.word : ~in_ch.word;
    push_job.base = (btil_pkg::IDX_W'(word_number_r) << btil_pkg::POS_W) + cfg.index_offset;
    push_job.last = in_ch.last_word;
  end

  always_comb begin
    word_number_nxt = word_number_r;
    if (push) begin
      if (in_ch.last_word || word_number_r == WN_W'(MAX_WORDS - 1)) begin
        word_number_nxt = '0;
      end else begin
        word_number_nxt = word_number_r + WN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_number_r <= '0;
    end else begin
      word_number_r <= word_number_nxt;
    end
  end

endmodule

@@ hw/rtl/btil_queue.sv @@
// Two-entry queue between the front end and the scanner.
`timescale 1ns / 1ps

module btil_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  btil_pkg::btil_job_t    push_job,
  input  logic                   pop,
  output btil_pkg::btil_job_t    pop_job,
  output btil_pkg::btil_q_stat_t stat
);

  localparam int unsigned CNT_BITS = btil_pkg::Q_PTR_W + 1;

  btil_pkg::btil_job_t              slot_r [btil_pkg::Q_DEPTH];
  logic [btil_pkg::Q_PTR_W-1:0]     wr_ptr_r;
  logic [btil_pkg::Q_PTR_W-1:0]     rd_ptr_r;
  logic [CNT_BITS-1:0]              count_r;
  logic [CNT_BITS-1:0]              count_nxt;

  assign stat.full  = (count_r == CNT_BITS'(btil_pkg::Q_DEPTH));
  assign stat.empty = (count_r == '0);
  assign pop_job    = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + btil_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + btil_pkg::Q_PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

@@ hw/rtl/btil_back.sv @@
// Scanner: peels off the lowest set bit each cycle out_ch does not stall and drives the result register.
`timescale 1ns / 1ps

module btil_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  btil_pkg::btil_q_stat_t q_stat,
  input  btil_pkg::btil_job_t    pop_job,
  output logic                   pop,
  btil_out_if.source             out_ch
);

  logic [btil_pkg::WORD_W-1:0] cur_word_r;
  logic [btil_pkg::IDX_W-1:0]  cur_base_r;
  logic                        cur_last_r;
  logic                        busy_r;
  logic [btil_pkg::CNT_W-1:0]  count_r;
  logic [btil_pkg::CNT_W-1:0]  count_nxt;
  logic                        out_valid_r;
  logic [btil_pkg::IDX_W-1:0]  index_r;
  logic [btil_pkg::IDX_W-1:0]  slot_r;
  logic                        found_r;
  logic                        last_of_word_r;

  logic                        emit;
  logic                        found;
  logic [btil_pkg::POS_W-1:0]  pos;
  logic [btil_pkg::WORD_W-1:0] rest;
  logic                        word_done;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.index        = index_r;
  assign out_ch.slot         = slot_r;
  assign out_ch.found        = found_r;
  assign out_ch.last_of_word = last_of_word_r;

  always_comb begin
    emit      = busy_r && (!out_valid_r || out_ch.ready);
    found     = |cur_word_r;
    pos       = btil_pkg::lowest_pos(cur_word_r);
    rest      = cur_word_r & (cur_word_r - btil_pkg::WORD_W'(1));
    word_done = !found || (rest == '0);
    // take the next word in the cycle the current one issues its final result
    pop       = !q_stat.empty && (!busy_r || (emit && word_done));
  end

  always_comb begin
    count_nxt = count_r;
    if (emit) begin
      if (word_done && cur_last_r) begin
        count_nxt = '0;
      end else if (found) begin
        count_nxt = count_r + btil_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_base_r <= pop_job.base;
      cur_last_r <= pop_job.last;
    end
    if (pop) begin
      cur_word_r <= pop_job.word;
    end else if (emit) begin
      cur_word_r <= rest;
    end
    if (emit) begin
      index_r        <= found ? cur_base_r + btil_pkg::IDX_W'(pos) : '0;
      slot_r         <= count_r[btil_pkg::IDX_W-1:0];
      found_r        <= found;
      last_of_word_r <= word_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
      end else if (emit && word_done) begin
        busy_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      count_r <= count_nxt;
    end
  end

endmodule

@@ hw/rtl/bitmap_to_index_list_unit.sv @@
// Top level of the bitmap to index list unit: registers, front end, queue and scanner.
//
//  channel   direction  handshake           payload
//  in_ch     in         valid / ready       word[63:0], last_word
//  out_ch    out        valid / ready       index[15:0], slot[15:0], found, last_of_word
//  apb       in         psel,penable,pready pwrite, paddr[2:0], pwdata/prdata[31:0]
//
// A word with k matching bits issues max(k,1) results, one per cycle while out_ch does not
// stall, as the scanner clears one bit per cycle; the next word is loaded in the cycle that
// issues the final result of the previous one, so results stream without gaps.
// Reset clears the counters and the queue and sets match_value to 1, index_offset to 0.
// A stall on out_ch holds the scanner; the two-entry queue accepts up to two more words
// on in_ch meanwhile, then in_ch stalls too.
`timescale 1ns / 1ps

module bitmap_to_index_list_unit #(
  parameter int unsigned MAX_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  btil_in_if.sink     in_ch,
  btil_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                       match_value_r;
  logic [btil_pkg::IDX_W-1:0] index_offset_r;
  btil_pkg::btil_reg_t        reg_sel;
  logic                       wr_en;

  btil_pkg::btil_cfg_t    cfg;
  btil_pkg::btil_q_stat_t q_stat;
  btil_pkg::btil_job_t    push_job;
  btil_pkg::btil_job_t    pop_job;
  logic                   push;
  logic                   pop;

  assign pready  = 1'b1;
  assign reg_sel = btil_pkg::btil_reg_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_sel)
      btil_pkg::REG_MATCH: prdata = {31'b0, match_value_r};
      btil_pkg::REG_BASE:  prdata = {16'b0, index_offset_r};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_value_r  <= 1'b1;
      index_offset_r <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        btil_pkg::REG_MATCH: match_value_r  <= pwdata[0];
        btil_pkg::REG_BASE:  index_offset_r <= pwdata[btil_pkg::IDX_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.match_value  = match_value_r;
  assign cfg.index_offset = index_offset_r;

  btil_front #(
    .MAX_WORDS (MAX_WORDS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg      (cfg),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  btil_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .stat     (q_stat)
  );

  btil_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_stat  (q_stat),
    .pop_job (pop_job),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

@@ test/tb_bitmap_to_index_list_unit.sv @@
// Testbench of the bitmap to index list unit: directed table, random batches and a long batch.
`timescale 1ns / 1ps

module tb_bitmap_to_index_list_unit;

  localparam int unsigned TB_MAX_WORDS = 1024;
  localparam int unsigned LONG_WORDS   = 30;
  localparam int unsigned PHASE_WORDS  = 80;
  localparam int unsigned NUM_ROWS     = 16;

  typedef enum logic [1:0] {
    PACE_NONE,
    PACE_SRC,
    PACE_SNK,
    PACE_BOTH
  } pace_e;

  typedef enum logic {
    ROW_WORD,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    logic [btil_pkg::IDX_W-1:0] index;
    logic [btil_pkg::IDX_W-1:0] slot;
    logic                       found;
    logic                       last_of_word;
  } hit_t;

  typedef struct packed {
    row_kind_e                   kind;
    logic [btil_pkg::WORD_W-1:0] word;
    logic                        last;
    logic                        typed;
    hit_t                        hit;
    logic [31:0]                 match_raw;
    logic [31:0]                 base_raw;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  btil_in_if  in_ch ();
  btil_out_if out_ch ();

  bitmap_to_index_list_unit #(
    .MAX_WORDS(TB_MAX_WORDS)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Predicted state and configuration.
  logic                       sel_value = 1'b1;
  logic [btil_pkg::IDX_W-1:0] base_off  = '0;
  logic [9:0]                 word_no   = '0;
  logic [btil_pkg::CNT_W-1:0] hit_count = '0;

  hit_t pending_hits [$];
  hit_t scan_hits [$];
  int   mismatches = 0;
  int   src_idle   = 0;
  int   snk_stall  = 0;
  row_t dir_rows [NUM_ROWS];

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #8000000;
    $display("Some tests failed");
    $finish;
  end

  // Work out the indexes one word yields and advance the batch counters.
  function automatic void scan_word(input logic [btil_pkg::WORD_W-1:0] w, input logic last);
    logic [btil_pkg::WORD_W-1:0] m;
    hit_t                        h;
    scan_hits.delete();
    m = sel_value ? w : ~w;
    for (int b = 0; b < btil_pkg::WORD_W; b++) begin
      if (m[b]) begin
        h.index        = {word_no, 6'(b)} + base_off;
        h.slot         = hit_count[btil_pkg::IDX_W-1:0];
        h.found        = 1'b1;
        h.last_of_word = 1'b0;
        scan_hits.push_back(h);
        hit_count = hit_count + 1'b1;
      end
    end
    if (scan_hits.size() == 0) begin
      h = '{'0, hit_count[btil_pkg::IDX_W-1:0], 1'b0, 1'b1};
      scan_hits.push_back(h);
    end else begin
      scan_hits[scan_hits.size()-1].last_of_word = 1'b1;
    end
    if (last) begin
      word_no   = '0;
      hit_count = '0;
    end else if (int'(word_no) + 1 >= TB_MAX_WORDS) begin
      word_no = '0;
    end else begin
      word_no = word_no + 1'b1;
    end
  endfunction

  // Mostly sparse words; when clear bits are searched, invert most of them.
  function automatic logic [btil_pkg::WORD_W-1:0] pick_word();
    logic [btil_pkg::WORD_W-1:0] w;
    case ($urandom_range(0, 9))
      0:       w = '0;
      1:       w = '1;
      2:       w = 64'h1 << $urandom_range(0, 63);
      3:       w = (64'h1 << $urandom_range(0, 63)) | (64'h1 << $urandom_range(0, 63));
      4, 5:    w = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      6, 7:    w = {$urandom, $urandom};
      default: w = {$urandom, $urandom} & {$urandom, $urandom};
    endcase
    if (!sel_value && $urandom_range(0, 4) != 0) begin
      w = ~w;
    end
    return w;
  endfunction

  task automatic set_pace(input pace_e p);
    src_idle  = (p == PACE_SRC) ? 80 : (p == PACE_BOTH) ? 18 : 0;
    snk_stall = (p == PACE_SNK) ? 80 : (p == PACE_BOTH) ? 18 : 0;
  endtask

  // Write a register, then read it back while still selected.
  task automatic cfg_set(input btil_pkg::btil_reg_t a, input logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {a, 2'b00};
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (a == btil_pkg::REG_MATCH) begin
      sel_value = d[0];
    end else begin
      base_off = d[btil_pkg::IDX_W-1:0];
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if ((a == btil_pkg::REG_MATCH && prdata[0] !== sel_value) ||
        (a == btil_pkg::REG_BASE && prdata[btil_pkg::IDX_W-1:0] !== base_off)) begin
      $display("%0t: register %h read back: expected %h, got %h", $time, a,
               (a == btil_pkg::REG_MATCH) ? 32'(sel_value) : 32'(base_off), prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_word(input logic [btil_pkg::WORD_W-1:0] w, input logic last,
                           input logic typed, input hit_t fixed);
    while ($urandom_range(0, 99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.word      <= w;
    in_ch.last_word <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    scan_word(w, last);
    if (typed) begin
      pending_hits.push_back(fixed);
    end else begin
      foreach (scan_hits[k]) pending_hits.push_back(scan_hits[k]);
    end
  endtask

  // Drop valid and let every expected index drain out.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Check each result against the oldest expectation, then pace the receiver.
  always @(posedge clk) begin
    hit_t got;
    hit_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.index, out_ch.slot, out_ch.found, out_ch.last_of_word};
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result: expected none, got index %h slot %h found %b last %b",
                 $time, got.index, got.slot, got.found, got.last_of_word);
        mismatches++;
      end else begin
        want = pending_hits.pop_front();
        if (got !== want) begin
          $display("%0t: result mismatch: expected index %h slot %h found %b last %b",
                   $time, want.index, want.slot, want.found, want.last_of_word);
          $display("%0t:                  got      index %h slot %h found %b last %b",
                   $time, got.index, got.slot, got.found, got.last_of_word);
          mismatches++;
        end
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= snk_stall);
  end

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.word      <= '0;
    in_ch.last_word <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;

    // Rows with a typed result follow from reset values and simple words.
    dir_rows[0]  = '{ROW_WORD, 64'h0, 1'b0, 1'b1, '{16'h0000, 16'h0000, 1'b0, 1'b1}, 0, 0};
    dir_rows[1]  = '{ROW_WORD, 64'h8000_0000_0000_0000, 1'b0, 1'b1,
                     '{16'h007F, 16'h0000, 1'b1, 1'b1}, 0, 0};
    dir_rows[2]  = '{ROW_WORD, 64'h1, 1'b1, 1'b1, '{16'h0080, 16'h0001, 1'b1, 1'b1}, 0, 0};
    dir_rows[3]  = '{ROW_WORD, '1, 1'b0, 1'b0, '0, 0, 0};
    dir_rows[4]  = '{ROW_WORD, 64'h0, 1'b1, 1'b1, '{16'h0000, 16'h0040, 1'b0, 1'b1}, 0, 0};
    dir_rows[5]  = '{ROW_WORD, 64'h8000_0000_0000_0001, 1'b0, 1'b0, '0, 0, 0};
    dir_rows[6]  = '{ROW_WORD, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0, '0, 0, 0};
    dir_rows[7]  = '{ROW_WORD, 64'h5555_5555_5555_5555, 1'b0, 1'b0, '0, 0, 0};
    dir_rows[8]  = '{ROW_WORD, 64'h0, 1'b0, 1'b1, '{16'h0000, 16'h0020, 1'b0, 1'b1}, 0, 0};
    // Upper bits of the written values must be masked off.
    dir_rows[9]  = '{ROW_CFG, '0, 1'b0, 1'b0, '0, 32'hFFFF_FFFE, 32'hABCD_FFFF};
    dir_rows[10] = '{ROW_WORD, '1, 1'b0, 1'b1, '{16'h0000, 16'h0020, 1'b0, 1'b1}, 0, 0};
    dir_rows[11] = '{ROW_WORD, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b0, '0, 0, 0};
    dir_rows[12] = '{ROW_WORD, 64'h0, 1'b1, 1'b0, '0, 0, 0};
    dir_rows[13] = '{ROW_CFG, '0, 1'b0, 1'b0, '0, 32'h0000_0001, 32'h0000_1234};
    dir_rows[14] = '{ROW_WORD, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, '0, 0, 0};
    dir_rows[15] = '{ROW_WORD, 64'h8000_0000_0000_0000, 1'b1, 1'b0, '0, 0, 0};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_pace(PACE_BOTH);
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        wait_idle();
        cfg_set(btil_pkg::REG_MATCH, dir_rows[r].match_raw);
        cfg_set(btil_pkg::REG_BASE, dir_rows[r].base_raw);
      end else begin
        send_word(dir_rows[r].word, dir_rows[r].last, dir_rows[r].typed, dir_rows[r].hit);
      end
    end

    // Random batches, one setting and one pace per phase, extremes of base first.
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      cfg_set(btil_pkg::REG_MATCH, ($urandom & ~32'h1) | ((p % 2 == 0) ? 32'h1 : 32'h0));
      cfg_set(btil_pkg::REG_BASE, (p == 0) ? 32'h0 : (p == 1) ? 32'hFFFF_FFFF : $urandom);
      set_pace(pace_e'(p));
      repeat (PHASE_WORDS) send_word(pick_word(), $urandom_range(0, 5) == 0, 1'b0, '0);
    end

    // One long batch of mostly dense words.
    wait_idle();
    cfg_set(btil_pkg::REG_MATCH, 32'h1);
    cfg_set(btil_pkg::REG_BASE, $urandom);
    set_pace(PACE_NONE);
    for (int k = 0; k < LONG_WORDS; k++) begin
      send_word(($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : '1,
                k == LONG_WORDS - 1, 1'b0, '0);
    end

    wait_idle();
    repeat (12) @(posedge clk);
    if (pending_hits.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_hits.size());
    end
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
